[sv/phase_accumulator_waveform_oscillator_core_assert.svh]
// assertion macros for the oscillator core
`ifndef PHASE_ACCUMULATOR_WAVEFORM_OSCILLATOR_CORE_ASSERT_SVH
`define PHASE_ACCUMULATOR_WAVEFORM_OSCILLATOR_CORE_ASSERT_SVH

// same-cycle implication under reset
`define PAW_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication under reset
`define PAW_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/paw_pkg.sv]
// shared types and constants of the oscillator core
package paw_pkg;

   localparam int CFG_W  = 32;
   localparam int ADDR_W = 4;
   localparam int WAVE_W = 2;
   localparam int SAMPLE_W = 16;

   localparam logic [1:0] REG_PHASE_INCREMENT  = 2'd0;
   localparam logic [1:0] REG_WAVEFORM         = 2'd1;
   localparam logic [1:0] REG_PULSE_THRESHOLD  = 2'd2;
   localparam logic [1:0] REG_SAMPLE_HOLD_STEP = 2'd3;

   localparam logic [CFG_W-1:0] PULSE_THRESHOLD_RESET = 32'h8000_0000;

   typedef enum logic [WAVE_W-1:0] {
      WAVE_SAW      = 2'd0,
      WAVE_TRIANGLE = 2'd1,
      WAVE_SQUARE   = 2'd2
   } wave_type;

   typedef struct packed {
      logic [CFG_W-1:0]  phase_increment;
      logic [WAVE_W-1:0] waveform;
      logic [CFG_W-1:0]  pulse_threshold;
      logic [CFG_W-1:0]  sample_hold_step;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

[sv/paw_csr.sv]
// configuration register file with apb-style access
module paw_csr import paw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [CFG_W-1:0]  csr_pwdata,
   output logic [CFG_W-1:0]  csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[3:2];
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_increment  <= '0;
         cfg_ff.waveform         <= '0;
         cfg_ff.pulse_threshold  <= PULSE_THRESHOLD_RESET;
         cfg_ff.sample_hold_step <= '0;
      end else if (wr_en) begin
         case (reg_idx)
            REG_PHASE_INCREMENT:  cfg_ff.phase_increment  <= csr_pwdata;
            REG_WAVEFORM:         cfg_ff.waveform         <= csr_pwdata[WAVE_W-1:0];
            REG_PULSE_THRESHOLD:  cfg_ff.pulse_threshold  <= csr_pwdata;
            REG_SAMPLE_HOLD_STEP: cfg_ff.sample_hold_step <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_PHASE_INCREMENT:  csr_prdata = cfg_ff.phase_increment;
         REG_WAVEFORM:         csr_prdata = CFG_W'(cfg_ff.waveform);
         REG_PULSE_THRESHOLD:  csr_prdata = cfg_ff.pulse_threshold;
         REG_SAMPLE_HOLD_STEP: csr_prdata = cfg_ff.sample_hold_step;
         default:              csr_prdata = '0;
      endcase
   end

endmodule

[sv/paw_mod_unit.sv]
// radix-2 restoring modulo unit, one quotient bit per cycle
module paw_mod_unit import paw_pkg::*; #(
   parameter int PHASE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [PHASE_BITS-1:0] dividend,
   input  logic [CFG_W-1:0]      divisor,
   output div_status_type        status,
   output logic [CFG_W-1:0]      remainder
);

   localparam int CNT_W = $clog2(PHASE_BITS + 1);

   logic [PHASE_BITS-1:0] num_ff;
   logic [CFG_W-1:0]      rem_ff;
   logic [CFG_W-1:0]      den_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  done_ff;
   logic [CFG_W:0]        trial;
   logic [CFG_W:0]        diff;
   logic                  fits;

   assign trial = {rem_ff, num_ff[PHASE_BITS-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            num_ff <= dividend;
            rem_ff <= '0;
            den_ff <= divisor;
            cnt_ff <= CNT_W'(PHASE_BITS);
         end else if (cnt_ff != '0) begin
            rem_ff <= fits ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
            num_ff <= {num_ff[PHASE_BITS-2:0], 1'b0};
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign status.busy = cnt_ff != '0;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

endmodule

[sv/paw_shaper.sv]
// saw, triangle and square shaping of the read phase; other waveform codes give zero
module paw_shaper import paw_pkg::*; #(
   parameter int PHASE_BITS = 32
) (
   input  logic [PHASE_BITS-1:0] phase,
   input  logic [WAVE_W-1:0]     waveform,
   input  logic [CFG_W-1:0]      threshold,
   output logic [SAMPLE_W-1:0]   sample
);

   localparam int EXT_W = (PHASE_BITS > CFG_W) ? PHASE_BITS : CFG_W;

   logic [14:0]       saw_bits;
   logic [15:0]       tri_bits;
   logic [16:0]       tri_fold;
   logic [EXT_W-1:0]  phase_ext;
   logic [EXT_W-1:0]  thr_ext;
   logic [1:0]        quadrant;

   assign saw_bits  = phase[PHASE_BITS-1 -: 15];
   assign tri_bits  = phase[PHASE_BITS-1 -: 16];
   assign tri_fold  = 17'd32768 - {1'b0, tri_bits};
   assign quadrant  = phase[PHASE_BITS-1 -: 2];
   assign phase_ext = EXT_W'(phase);
   assign thr_ext   = EXT_W'(threshold);

   always_comb begin
      case (wave_type'(waveform))
         WAVE_SAW:      sample = {1'b0, saw_bits} - 16'd16384;
         WAVE_TRIANGLE: begin
            case (quadrant)
               2'b00:   sample = tri_bits;
               2'b11:   sample = tri_bits;
               default: sample = tri_fold[15:0];
            endcase
         end
         WAVE_SQUARE:   sample = (phase_ext < thr_ext) ? 16'h4000 : 16'hC000;
         default:       sample = '0;
      endcase
   end

endmodule

[sv/phase_accumulator_waveform_oscillator_core.sv]
// top level of the phase-accumulator waveform oscillator
// an accepted request runs the offset step, then with sample hold on the divide and
//   quantise steps (one modulo bit per cycle), then the output step fills the result slot
// a new request is accepted only in idle, after the previous one has filled the result
//   slot; the output step waits while the slot holds a stalled result
// synchronous reset clears phase and control state and resets the config registers; result slot empty
module phase_accumulator_waveform_oscillator_core import paw_pkg::*; #(
   parameter int PHASE_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_cmd,
   input  logic [CFG_W-1:0]     req_phase_value,
   input  logic [CFG_W-1:0]     req_phase_offset,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [SAMPLE_W-1:0]  rsp_sample,
   output logic [CFG_W-1:0]     rsp_read_phase,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [ADDR_W-1:0]    csr_paddr,
   input  logic [CFG_W-1:0]     csr_pwdata,
   output logic [CFG_W-1:0]     csr_prdata,
   output logic                 csr_pready
);

`include "phase_accumulator_waveform_oscillator_core_assert.svh"

   localparam int EXT_W = (PHASE_BITS > CFG_W) ? PHASE_BITS : CFG_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_OFFSET,
      S_DIVIDE,
      S_QUANT,
      S_OUTPUT
   } state_type;

   state_type             state_ff;
   cfg_type               cfg;
   div_status_type        div_stat;
   logic                  div_start;
   logic [CFG_W-1:0]      rem;
   logic [PHASE_BITS-1:0] acc_ff;
   logic [PHASE_BITS-1:0] off_ff;
   logic [PHASE_BITS-1:0] rd_ff;
   logic [PHASE_BITS-1:0] rd_sum;
   logic [EXT_W-1:0]      inc_ext;
   logic [EXT_W-1:0]      val_ext;
   logic [EXT_W-1:0]      off_ext;
   logic [EXT_W-1:0]      rd_ext;
   logic [EXT_W-1:0]      rem_ext;
   logic [SAMPLE_W-1:0]   sample;
   logic                  rsp_valid_ff;
   logic [SAMPLE_W-1:0]   rsp_sample_ff;
   logic [CFG_W-1:0]      rsp_read_phase_ff;
   logic                  req_accept;
   logic                  step_on;
   logic                  slot_free;

   paw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   paw_mod_unit #(.PHASE_BITS(PHASE_BITS)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (rd_sum),
      .divisor   (cfg.sample_hold_step),
      .status    (div_stat),
      .remainder (rem)
   );

   paw_shaper #(.PHASE_BITS(PHASE_BITS)) u_shaper (
      .phase     (rd_ff),
      .waveform  (cfg.waveform),
      .threshold (cfg.pulse_threshold),
      .sample    (sample)
   );

   assign inc_ext    = EXT_W'(cfg.phase_increment);
   assign val_ext    = EXT_W'(req_phase_value);
   assign off_ext    = EXT_W'(req_phase_offset);
   assign rd_ext     = EXT_W'(rd_ff);
   assign rem_ext    = EXT_W'(rem);
   assign rd_sum     = acc_ff + off_ff;
   assign step_on    = cfg.sample_hold_step != '0;
   assign req_stall  = state_ff != S_IDLE;
   assign req_accept = req_valid & ~req_stall;
   assign slot_free  = ~rsp_valid_ff | ~rsp_stall;
   assign div_start  = (state_ff == S_OFFSET) & step_on;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff & ~rsp_stall & (state_ff != S_OUTPUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  acc_ff   <= req_cmd ? val_ext[PHASE_BITS-1:0]
                                      : acc_ff + inc_ext[PHASE_BITS-1:0];
                  off_ff   <= off_ext[PHASE_BITS-1:0];
                  state_ff <= S_OFFSET;
               end
            end
            S_OFFSET: begin
               rd_ff    <= rd_sum;
               state_ff <= step_on ? S_DIVIDE : S_OUTPUT;
            end
            S_DIVIDE: begin
               if (div_stat.done) begin
                  state_ff <= S_QUANT;
               end
            end
            S_QUANT: begin
               rd_ff    <= rd_ff - rem_ext[PHASE_BITS-1:0];
               state_ff <= S_OUTPUT;
            end
            S_OUTPUT: begin
               if (slot_free) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_sample_ff     <= sample;
                  rsp_read_phase_ff <= rd_ext[CFG_W-1:0];
                  state_ff          <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample     = rsp_sample_ff;
   assign rsp_read_phase = rsp_read_phase_ff;

   `PAW_ASSERT_IMP(a_div_start_free, div_start, !div_stat.busy,
                   "modulo unit started while busy")
   `PAW_ASSERT_NXT(a_accept_offset, req_accept, state_ff == S_OFFSET,
                   "accepted transfer did not move to offset step")
   `PAW_ASSERT_IMP(a_rem_below_step, state_ff == S_QUANT,
                   rem < cfg.sample_hold_step && rem_ext <= rd_ext,
                   "remainder out of range")
   `PAW_ASSERT_IMP(a_result_from_output, $rose(rsp_valid_ff),
                   $past(state_ff) == S_OUTPUT,
                   "result slot filled outside output step")

endmodule

[sim/phase_accumulator_waveform_oscillator_core_tb.sv]
// testbench for the phase-accumulator waveform oscillator core
module phase_accumulator_waveform_oscillator_core_tb import paw_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASE_BITS = 32;
   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 2 * (PHASE_BITS + 5);
   localparam logic [WAVE_W-1:0] WAVE_UNUSED = 2'd3;
   localparam logic [CFG_W-1:0] QUARTER = 32'h4000_0000;
   localparam logic [CFG_W-1:0] THREE_QUARTERS = 32'hC000_0000;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [CFG_W-1:0]    read_phase;
   } osc_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_cmd = 1'b0;
   logic [CFG_W-1:0]    req_phase_value = '0;
   logic [CFG_W-1:0]    req_phase_offset = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [SAMPLE_W-1:0] rsp_sample;
   logic [CFG_W-1:0]    rsp_read_phase;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]   csr_paddr = '0;
   logic [CFG_W-1:0]    csr_pwdata = '0;
   logic [CFG_W-1:0]    csr_prdata;
   logic                csr_pready;

   osc_result_type   expected_samples[$];
   logic [CFG_W-1:0] model_phase = '0;
   cfg_type          model_cfg;
   int               mismatch_count = 0;
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;
   int               hold_len = 0;
   int               quiet_cycles = 0;

   phase_accumulator_waveform_oscillator_core #(
      .PHASE_BITS(PHASE_BITS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_phase_value(req_phase_value),
      .req_phase_offset(req_phase_offset),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_sample(rsp_sample),
      .rsp_read_phase(rsp_read_phase),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #1 clock = ~clock;

   function automatic logic [SAMPLE_W-1:0] shape_read_phase(input logic [CFG_W-1:0] p);
      int t;
      case (model_cfg.waveform)
         WAVE_SAW: begin
            t = int'(p >> (PHASE_BITS - 15)) - 16384;
         end
         WAVE_TRIANGLE: begin
            t = int'(p >> (PHASE_BITS - 16));
            if (p >= THREE_QUARTERS) begin
               t = t - 65536;
            end else if (p >= QUARTER) begin
               t = 32768 - t;
            end
         end
         WAVE_SQUARE: begin
            t = (p < model_cfg.pulse_threshold) ? 16384 : -16384;
         end
         default: begin
            t = 0;
         end
      endcase
      return t[SAMPLE_W-1:0];
   endfunction

   function automatic osc_result_type advance_oscillator(input logic cmd,
                                                         input logic [CFG_W-1:0] value,
                                                         input logic [CFG_W-1:0] offset);
      osc_result_type r;
      logic [CFG_W-1:0] rd;
      if (cmd) begin
         model_phase = value;
      end else begin
         model_phase = model_phase + model_cfg.phase_increment;
      end
      rd = model_phase + offset;
      if (model_cfg.sample_hold_step != '0) begin
         rd = rd - (rd % model_cfg.sample_hold_step);
      end
      r.sample = shape_read_phase(rd);
      r.read_phase = rd;
      return r;
   endfunction

   function automatic logic [CFG_W-1:0] pick_word();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return 32'd1 << $urandom_range(31);
         default: return $urandom;
      endcase
   endfunction

   // every task that waits on the clock starts and ends at a falling edge
   task automatic send_item(input logic cmd, input logic [CFG_W-1:0] value,
                            input logic [CFG_W-1:0] offset);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_phase_value <= value;
      req_phase_offset <= offset;
      do @(posedge clock); while (req_stall);
      expected_samples.push_back(advance_oscillator(cmd, value, offset));
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
      drain_results();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= ADDR_W'({idx, 2'b00});
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_PHASE_INCREMENT:  model_cfg.phase_increment = value;
         REG_WAVEFORM:         model_cfg.waveform = value[WAVE_W-1:0];
         REG_PULSE_THRESHOLD:  model_cfg.pulse_threshold = value;
         REG_SAMPLE_HOLD_STEP: model_cfg.sample_hold_step = value;
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      send_idle_pct = sender_pct;
      recv_stall_pct <= receiver_pct;
   endtask

   task automatic test_reset_state();
      send_item(1'b0, '0, '0);
      send_item(1'b1, 32'hFFFF_FFFF, '0);
      send_item(1'b1, 32'h8000_0000, 32'h8000_0000);
   endtask

   task automatic test_waveform_edges();
      write_reg(REG_PHASE_INCREMENT, 32'hFFFF_FFFF);
      send_item(1'b0, '0, 32'hFFFF_FFFF);
      send_item(1'b0, '0, '0);
      write_reg(REG_WAVEFORM, CFG_W'(WAVE_TRIANGLE));
      send_item(1'b1, 32'h3FFF_FFFF, '0);
      send_item(1'b1, QUARTER, '0);
      send_item(1'b1, 32'h7FFF_FFFF, '0);
      send_item(1'b1, 32'hBFFF_FFFF, '0);
      send_item(1'b1, THREE_QUARTERS, '0);
      send_item(1'b1, 32'hFFFF_FFFF, '0);
      write_reg(REG_WAVEFORM, CFG_W'(WAVE_SQUARE));
      write_reg(REG_PULSE_THRESHOLD, '0);
      send_item(1'b1, '0, '0);
      send_item(1'b1, 32'h8000_0000, '0);
      write_reg(REG_PULSE_THRESHOLD, 32'hFFFF_FFFF);
      send_item(1'b1, '0, '0);
      send_item(1'b1, 32'hFFFF_FFFF, '0);
      write_reg(REG_WAVEFORM, CFG_W'(WAVE_UNUSED));
      send_item(1'b1, 32'h1234_5678, '0);
   endtask

   task automatic test_sample_hold_edges();
      write_reg(REG_WAVEFORM, CFG_W'(WAVE_SAW));
      write_reg(REG_SAMPLE_HOLD_STEP, 32'hFFFF_FFFF);
      send_item(1'b1, 32'hFFFF_FFFE, '0);
      send_item(1'b1, 32'hFFFF_FFFF, '0);
      write_reg(REG_SAMPLE_HOLD_STEP, 32'd1);
      send_item(1'b1, 32'hDEAD_BEEF, 32'h0000_0001);
      write_reg(REG_SAMPLE_HOLD_STEP, 32'h1000_0000);
      send_item(1'b1, 32'h7654_3210, 32'hF000_0000);
   endtask

   task automatic test_backpressure();
      write_reg(REG_SAMPLE_HOLD_STEP, '0);
      write_reg(REG_PHASE_INCREMENT, 32'h0123_4567);
      set_idling(0, 0);
      hold_len <= 400;
      repeat (12) send_item(1'b0, '0, $urandom);
      drain_results();
   endtask

   task automatic randomise_config();
      write_reg(REG_PHASE_INCREMENT, pick_word());
      write_reg(REG_WAVEFORM, CFG_W'($urandom_range(3)));
      write_reg(REG_PULSE_THRESHOLD, pick_word());
      case ($urandom_range(3))
         0: write_reg(REG_SAMPLE_HOLD_STEP, CFG_W'($urandom_range(1000, 1)));
         1: write_reg(REG_SAMPLE_HOLD_STEP, pick_word());
         default: write_reg(REG_SAMPLE_HOLD_STEP, '0);
      endcase
   endtask

   task automatic test_random(input int sender_pct, input int receiver_pct, input int items);
      drain_results();
      set_idling(sender_pct, receiver_pct);
      repeat (6) begin
         randomise_config();
         repeat (items / 6) begin
            send_item($urandom_range(9) < 2, pick_word(),
                      $urandom_range(1) ? '0 : pick_word());
         end
      end
   endtask

   always @(negedge clock) begin
      if (hold_len > 0) begin
         rsp_stall <= 1'b1;
         hold_len <= hold_len - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      osc_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_samples.size() == 0) begin
            $display("%0t: unexpected transfer sample %h read_phase %h",
                     $time, rsp_sample, rsp_read_phase);
            mismatch_count++;
         end else begin
            want = expected_samples.pop_front();
            if (rsp_sample !== want.sample) begin
               $display("%0t: sample expected %h actual %h", $time, want.sample, rsp_sample);
               mismatch_count++;
            end
            if (rsp_read_phase !== want.read_phase) begin
               $display("%0t: read_phase expected %h actual %h",
                        $time, want.read_phase, rsp_read_phase);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("phase_accumulator_waveform_oscillator_core_tb: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      model_cfg.phase_increment = '0;
      model_cfg.waveform = WAVE_SAW;
      model_cfg.pulse_threshold = PULSE_THRESHOLD_RESET;
      model_cfg.sample_hold_step = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_state();
      test_waveform_edges();
      test_sample_hold_edges();
      test_backpressure();
      test_random(12, 77, 700);
      test_random(77, 12, 700);
      test_random(0, 0, 600);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_samples.size() == 0) begin
         $display("phase_accumulator_waveform_oscillator_core_tb: PASS");
      end else begin
         $display("phase_accumulator_waveform_oscillator_core_tb: FAIL");
      end
      $finish;
   end

endmodule
